[src/rth_pkg.sv]
// Package with shared constants for the RGB to HSL pixel converter.
`timescale 1ns / 1ps
`default_nettype none
package rth_pkg;
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int QUO_W = 9;
    localparam int HUE_EXT = 9;
    localparam int SAT_EXT = 7;
    localparam int LIT_EXT = 8;
endpackage
`default_nettype wire

[src/rth_front.sv]
// Front classifier: extremes, hue sector and division operands for one item.
`timescale 1ns / 1ps
`default_nettype none
module rth_front
    import rth_pkg::*;
#(
    parameter int CB = 8
) (
    input  wire logic [CB-1:0]         red,
    input  wire logic [CB-1:0]         green,
    input  wire logic [CB-1:0]         blue,
    output logic [CB+HUE_EXT-1:0]      hue_num,
    output logic [CB-1:0]              hue_den,
    output logic [CB+SAT_EXT-1:0]      sat_num,
    output logic [CB:0]                sat_den,
    output logic [CB+LIT_EXT-1:0]      lit_num
);
    localparam int HW = CB + HUE_EXT;
    localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};
    localparam logic [CB:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

    logic [CB-1:0] mx;
    logic [CB-1:0] mn;
    logic [CB-1:0] d;
    logic [CB:0]   sum;
    logic [HW-1:0] dw;
    logic [HW-1:0] rw;
    logic [HW-1:0] gw;
    logic [HW-1:0] bw;
    logic [HW-1:0] num;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        dw  = HW'(d);
        rw  = HW'(red);
        gw  = HW'(green);
        bw  = HW'(blue);
        if (mx == red)
        begin
            if (green >= blue)
            begin
                num = HW'(60) * (gw - bw);
            end
            else
            begin
                num = HW'(360) * dw - HW'(60) * (bw - gw);
            end
        end
        else if (mx == green)
        begin
            num = HW'(120) * dw + HW'(60) * bw - HW'(60) * rw;
        end
        else
        begin
            num = HW'(240) * dw + HW'(60) * rw - HW'(60) * gw;
        end
        lit_num = (CB+LIT_EXT)'(50) * (CB+LIT_EXT)'(sum);
        if (d == '0)
        begin
            hue_num = '0;
            hue_den = CB'(1);
            sat_num = '0;
            sat_den = (CB+1)'(1);
        end
        else
        begin
            hue_num = num;
            hue_den = d;
            sat_num = (CB+SAT_EXT)'(100) * (CB+SAT_EXT)'(d);
            sat_den = (sum > FULL) ? (TWO_FULL - sum) : sum;
        end
    end
endmodule
`default_nettype wire

[src/rth_fifo.sv]
// Two-entry queue between the front classifier and the divider pipelines.
`timescale 1ns / 1ps
`default_nettype none
module rth_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    output logic              pop,
    output logic [W-1:0]      rdata
);
    logic [W-1:0] mem_reg [0:1];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign pop   = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[src/rth_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rth_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               out_valid,
    output logic [QW-1:0]      quo
);
    localparam int XW = NW + QW;

    logic [NW-1:0] rem_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic          vld_reg [0:QW];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [XW-1:0] sh;
        logic          ge;
        assign sh = XW'(den_reg[s]) << (QW - 1 - s);
        assign ge = XW'(rem_reg[s]) >= sh;

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_reg[s];
            rem_reg[s+1] <= ge ? NW'(XW'(rem_reg[s]) - sh) : rem_reg[s];
            quo_reg[s+1] <= quo_reg[s] | (QW'(ge) << (QW - 1 - s));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = quo_reg[QW];
endmodule
`default_nettype wire

[src/rgb_to_hsl_pixel.sv]
// Top level of the RGB to HSL pixel converter.
//
//  channel | handshake          | payload
//  in      | start, busy        | red, green, blue
//  out     | done (one cycle)   | hue, saturation, lightness
//
// An item is taken each cycle while busy is low; its result passes through the queue register
// and then the 10 registers of each divider pipeline.
// Lightness divides by a constant with two shift-add folds and a compare, delayed to match.
// Reset clears the queue and all stage valid bits; no clearing pass.
// The back end never stalls, so busy only rises if the queue were full.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsl_pixel
    import rth_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output logic                         done,
    output logic [HUE_W-1:0]             hue,
    output logic [PCT_W-1:0]             saturation,
    output logic [PCT_W-1:0]             lightness
);
    localparam int CB  = CHANNEL_BITS;
    localparam int HNW = CB + HUE_EXT;
    localparam int SNW = CB + SAT_EXT;
    localparam int LNW = CB + LIT_EXT;
    localparam int W   = HNW + CB + SNW + CB + 1 + LNW;
    localparam int LIT_DLY = QUO_W - 1;
    localparam logic [LNW-1:0] CMAX = LNW'({CB{1'b1}});

    logic [HNW-1:0] f_hue_num;
    logic [CB-1:0]  f_hue_den;
    logic [SNW-1:0] f_sat_num;
    logic [CB:0]    f_sat_den;
    logic [LNW-1:0] f_lit_num;
    logic [HNW-1:0] q_hue_num;
    logic [CB-1:0]  q_hue_den;
    logic [SNW-1:0] q_sat_num;
    logic [CB:0]    q_sat_den;
    logic [LNW-1:0] q_lit_num;
    logic [W-1:0]   rdata;
    logic           pop;
    logic           full;
    logic           hue_vld;
    logic           sat_vld;
    logic [QUO_W-1:0] hue_q;
    logic [QUO_W-1:0] sat_q;
    logic [LNW-1:0] lit_a_q_reg;
    logic [LNW-1:0] lit_a_y_reg;
    logic [LNW-1:0] lit_b_q_reg;
    logic [LNW-1:0] lit_b_y_reg;
    logic [PCT_W-1:0] lit_pipe_reg [0:LIT_DLY-1];

    rth_front #(.CB(CB)) u_front (
        .red     (red),
        .green   (green),
        .blue    (blue),
        .hue_num (f_hue_num),
        .hue_den (f_hue_den),
        .sat_num (f_sat_num),
        .sat_den (f_sat_den),
        .lit_num (f_lit_num)
    );

    rth_fifo #(.W(W)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (start && !busy),
        .wdata ({f_hue_num, f_hue_den, f_sat_num, f_sat_den, f_lit_num}),
        .full  (full),
        .pop   (pop),
        .rdata (rdata)
    );

    assign busy = full;
    assign {q_hue_num, q_hue_den, q_sat_num, q_sat_den, q_lit_num} = rdata;

    rth_div #(.NW(HNW), .DW(CB), .QW(QUO_W)) u_div_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .num       (q_hue_num),
        .den       (q_hue_den),
        .out_valid (hue_vld),
        .quo       (hue_q)
    );

    rth_div #(.NW(SNW), .DW(CB + 1), .QW(QUO_W)) u_div_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .num       (q_sat_num),
        .den       (q_sat_den),
        .out_valid (sat_vld),
        .quo       (sat_q)
    );

    // fold by 2^CB - 1 twice, then one compare finishes the quotient
    always_ff @(posedge clk)
    begin
        lit_a_q_reg     <= q_lit_num >> CB;
        lit_a_y_reg     <= (q_lit_num >> CB) + (q_lit_num & CMAX);
        lit_b_q_reg     <= lit_a_q_reg + (lit_a_y_reg >> CB);
        lit_b_y_reg     <= (lit_a_y_reg >> CB) + (lit_a_y_reg & CMAX);
        lit_pipe_reg[0] <= PCT_W'(lit_b_q_reg + LNW'(lit_b_y_reg >= CMAX));
        for (int i = 1; i < LIT_DLY; i++)
        begin
            lit_pipe_reg[i] <= lit_pipe_reg[i-1];
        end
    end

    assign done       = hue_vld && sat_vld;
    assign hue        = hue_q;
    assign saturation = PCT_W'(sat_q);
    assign lightness  = lit_pipe_reg[LIT_DLY-1];
endmodule
`default_nettype wire

[src/rth_checker.sv]
// Port-level checker for the RGB to HSL pixel converter, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rth_checker
    import rth_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic [HUE_W-1:0] hue,
    input wire logic [PCT_W-1:0] saturation,
    input wire logic [PCT_W-1:0] lightness
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue < 9'd360 && saturation <= 7'd100 && lightness <= 7'd100))
        else $error("result out of range");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 done)
        else $error("result missing");
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        ##11 done |-> $past(start && !busy, 11))
        else $error("result without item");
endmodule

bind rgb_to_hsl_pixel rth_checker u_rth_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
);
`default_nettype wire

[tb/sv/rgb_to_hsl_pixel_tb.sv]
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsl_pixel_tb;
    import rth_pkg::*;

    localparam int CHANNEL_BITS = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 1300;
    localparam int NO_CHECK = -1;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] lit;
    } hsl_t;

    typedef struct {
        int r;
        int g;
        int b;
        int hue;
        int sat;
        int lit;
    } pixel_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CHANNEL_BITS-1:0] red = '0;
    logic [CHANNEL_BITS-1:0] green = '0;
    logic [CHANNEL_BITS-1:0] blue = '0;
    logic                    done;
    logic [HUE_W-1:0]        hue;
    logic [PCT_W-1:0]        saturation;
    logic [PCT_W-1:0]        lightness;

    hsl_t pending_hsl[$];
    int   errors = 0;
    int   pixels_sent = 0;
    int   results_seen = 0;
    int   gray_pixels = 0;
    int   idle_cycles = 0;
    bit   timed_out = 1'b0;

    rgb_to_hsl_pixel #(.CHANNEL_BITS(CHANNEL_BITS)) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic hsl_t convert_pixel(input int r, input int g, input int b);
        longint full;
        longint two_full;
        longint mx;
        longint mn;
        longint d;
        longint sum;
        longint num;
        hsl_t   res;
        full = (64'd1 << CHANNEL_BITS) - 1;
        two_full = 2 * full;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        res.lit = PCT_W'((100 * sum) / two_full);
        res.hue = '0;
        res.sat = '0;
        if (mx != mn)
        begin
            d = mx - mn;
            if (sum > full)
                res.sat = PCT_W'((100 * d) / (two_full - sum));
            else
                res.sat = PCT_W'((100 * d) / sum);
            if (mx == r)
                num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
            else if (mx == g)
                num = 120 * d + 60 * (b - r);
            else
                num = 240 * d + 60 * (r - g);
            res.hue = HUE_W'(num / d);
        end
        return res;
    endfunction

    // now and then hold off a random number of cycles, mostly short
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 3) != 0)
            return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_pixel(input int r, input int g, input int b, input int xh,
                              input int xs, input int xl);
        hsl_t exp_hsl;
        bit   accepted;
        exp_hsl = convert_pixel(r, g, b);
        if (xh != NO_CHECK && (xh != exp_hsl.hue || xs != exp_hsl.sat || xl != exp_hsl.lit))
        begin
            $error("table row %0d %0d %0d disagrees with prediction", r, g, b);
            errors++;
        end
        start <= 1'b1;
        red <= r[CHANNEL_BITS-1:0];
        green <= g[CHANNEL_BITS-1:0];
        blue <= b[CHANNEL_BITS-1:0];
        accepted = 1'b0;
        while (!accepted)
        begin
            #0 accepted = !busy;
            @(posedge clk);
        end
        pending_hsl.push_back(exp_hsl);
        pixels_sent++;
        if (r == g && g == b)
            gray_pixels++;
        @(negedge clk);
    endtask

    pixel_row_t pixel_table[] = '{
        '{0, 0, 0, 0, 0, 0},
        '{255, 255, 255, 0, 0, 100},
        '{128, 128, 128, 0, 0, 50},
        '{255, 0, 0, 0, 100, 50},
        '{0, 255, 0, 120, 100, 50},
        '{0, 0, 255, 240, 100, 50},
        '{255, 255, 0, 60, 100, 50},
        '{0, 255, 255, 180, 100, 50},
        '{255, 0, 255, 300, 100, 50},
        '{255, 0, 1, NO_CHECK, 0, 0},
        '{255, 254, 254, NO_CHECK, 0, 0},
        '{1, 0, 0, NO_CHECK, 0, 0},
        '{254, 255, 255, NO_CHECK, 0, 0},
        '{200, 100, 150, NO_CHECK, 0, 0},
        '{100, 200, 200, NO_CHECK, 0, 0},
        '{50, 50, 200, NO_CHECK, 0, 0},
        '{10, 250, 10, NO_CHECK, 0, 0},
        '{127, 128, 0, NO_CHECK, 0, 0},
        '{170, 85, 85, NO_CHECK, 0, 0},
        '{85, 170, 0, NO_CHECK, 0, 0}
    };

    always @(posedge clk)
    begin
        hsl_t exp_hsl;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_hsl.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
            end
            else
            begin
                exp_hsl = pending_hsl.pop_front();
                if (hue !== exp_hsl.hue)
                begin
                    $error("hue expected %0d actual %0d", exp_hsl.hue, hue);
                    errors++;
                end
                if (saturation !== exp_hsl.sat)
                begin
                    $error("saturation expected %0d actual %0d", exp_hsl.sat, saturation);
                    errors++;
                end
                if (lightness !== exp_hsl.lit)
                begin
                    $error("lightness expected %0d actual %0d", exp_hsl.lit, lightness);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rgb_to_hsl_pixel verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int g;
        int b;
        int wait_cycles;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (pixel_table[i])
        begin
            send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b,
                       pixel_table[i].hue, pixel_table[i].sat, pixel_table[i].lit);
            if (i > 10)
                idle_gap();
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            case ($urandom_range(0, 7))
                0: begin g = r; b = r; end
                1: g = r;
                2: b = g;
                3: b = r;
                4: begin r = 255; b = $urandom_range(0, 3); end
                default: ;
            endcase
            send_pixel(r, g, b, NO_CHECK, 0, 0);
            if (n % 200 > 40)
                idle_gap();
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_hsl.size() != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        timed_out = (pending_hsl.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Converted %0d pixels (%0d gray) with %0d results checked.",
                 pixels_sent, gray_pixels, results_seen);
        if (errors == 0 && !timed_out)
            $display("rgb_to_hsl_pixel verification clean");
        else
            $display("rgb_to_hsl_pixel verification failed");
        $finish;
    end
endmodule
`default_nettype wire
